// ----- src/alr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and constants for the ACL to L2CAP reassembly block.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int CONNECTION_SLOTS = 4;
    localparam int SLOT_W           = 2;
    localparam int HANDLE_W         = 12;
    localparam int CODE_W           = 2;
    localparam int BYTE_W           = 8;
    localparam int TOTAL_W          = 16;
    localparam int OFFSET_W         = 17;
    localparam int ADDR_W           = 5;
    localparam int DATA_W           = 32;

    localparam logic [CODE_W-1:0]   START_CODE   = 2'd2;
    localparam logic [OFFSET_W-1:0] HEADER_LAST  = 17'd3;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_HANDLE_0 = 3'd0,
        REG_HANDLE_1 = 3'd1,
        REG_HANDLE_2 = 3'd2,
        REG_HANDLE_3 = 3'd3,
        REG_ENABLE   = 3'd4
    } t_reg_idx;

    // per-slot frame state held in the state memory
    typedef struct packed {
        logic                frame_open;
        logic [TOTAL_W-1:0]  payload_total;
        logic [OFFSET_W-1:0] bytes_received;
        logic [BYTE_W-1:0]   length_low;
    } t_slot_state;

    // handle lookup result
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_match;

    // one result item
    typedef struct packed {
        logic                emit;
        logic [OFFSET_W-1:0] offset;
        logic                frame_end;
        logic                discarded;
    } t_result;

endpackage

// ----- src/alr_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_cfg_regs
// Configuration registers on the APB port and the connection handle lookup.
// ----------------------------------------------------------------------------
module alr_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [alr_pkg::ADDR_W-1:0]    paddr,
    input  logic [alr_pkg::DATA_W-1:0]    pwdata,
    output logic [alr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic [alr_pkg::HANDLE_W-1:0]  i_handle,
    output alr_pkg::t_match               o_match
);

    logic [alr_pkg::HANDLE_W-1:0]         r_handle [alr_pkg::CONNECTION_SLOTS];
    logic [alr_pkg::CONNECTION_SLOTS-1:0] r_enable;
    logic                                 wr_en;
    alr_pkg::t_reg_idx                    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = alr_pkg::t_reg_idx'(paddr[alr_pkg::ADDR_W-1:2]);

    // write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < alr_pkg::CONNECTION_SLOTS; i++) begin
                r_handle[i] <= '0;
            end
            r_enable <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                alr_pkg::REG_HANDLE_0: r_handle[0] <= pwdata[alr_pkg::HANDLE_W-1:0];
                alr_pkg::REG_HANDLE_1: r_handle[1] <= pwdata[alr_pkg::HANDLE_W-1:0];
                alr_pkg::REG_HANDLE_2: r_handle[2] <= pwdata[alr_pkg::HANDLE_W-1:0];
                alr_pkg::REG_HANDLE_3: r_handle[3] <= pwdata[alr_pkg::HANDLE_W-1:0];
                alr_pkg::REG_ENABLE:   r_enable <= pwdata[alr_pkg::CONNECTION_SLOTS-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            alr_pkg::REG_HANDLE_0: prdata[alr_pkg::HANDLE_W-1:0] = r_handle[0];
            alr_pkg::REG_HANDLE_1: prdata[alr_pkg::HANDLE_W-1:0] = r_handle[1];
            alr_pkg::REG_HANDLE_2: prdata[alr_pkg::HANDLE_W-1:0] = r_handle[2];
            alr_pkg::REG_HANDLE_3: prdata[alr_pkg::HANDLE_W-1:0] = r_handle[3];
            alr_pkg::REG_ENABLE:   prdata[alr_pkg::CONNECTION_SLOTS-1:0] = r_enable;
            default: ;
        endcase
    end

    // find the lowest enabled slot with a matching handle
    always_comb begin
        o_match = '0;
        for (int i = alr_pkg::CONNECTION_SLOTS - 1; i >= 0; i--) begin
            if (r_enable[i] && (r_handle[i] == i_handle)) begin
                o_match.hit  = 1'b1;
                o_match.slot = alr_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

// ----- src/alr_state_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_state_ram
// Per-slot frame state memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module alr_state_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [alr_pkg::SLOT_W-1:0]  i_rd_addr,
    output alr_pkg::t_slot_state        o_rd_data,
    input  logic                        i_wr_en,
    input  logic [alr_pkg::SLOT_W-1:0]  i_wr_addr,
    input  alr_pkg::t_slot_state        i_wr_data
);

    alr_pkg::t_slot_state                 mem [alr_pkg::CONNECTION_SLOTS];
    logic [alr_pkg::CONNECTION_SLOTS-1:0] r_written;
    alr_pkg::t_slot_state                 r_rd_data;
    logic                                 r_rd_written;

    // written marks: an entry never written reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, held while no new read is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_written <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_written <= r_written[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : '0;

endmodule

// ----- src/alr_frame_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_frame_update
// Next slot state and result for one byte: start, length capture, end check.
// ----------------------------------------------------------------------------
module alr_frame_update (
    input  alr_pkg::t_slot_state        i_state,
    input  logic [alr_pkg::CODE_W-1:0]  i_code,
    input  logic                        i_first,
    input  logic [alr_pkg::BYTE_W-1:0]  i_byte,
    output alr_pkg::t_slot_state        o_state,
    output alr_pkg::t_result            o_result
);

    logic                          start;
    logic [alr_pkg::OFFSET_W-1:0]  last_off;
    alr_pkg::t_slot_state          st;

    assign start = i_first && (i_code == alr_pkg::START_CODE);

    always_comb begin
        st = i_state;
        // open a new frame, dropping any partial one
        if (start) begin
            st = '0;
            st.frame_open = 1'b1;
        end
        o_result           = '0;
        o_result.emit      = st.frame_open;
        o_result.offset    = st.bytes_received;
        o_result.discarded = start && i_state.frame_open;
        o_state            = st;
        last_off           = '0;
        if (st.frame_open) begin
            // capture the little-endian length
            if (st.bytes_received == '0) begin
                o_state.length_low = i_byte;
            end else if (st.bytes_received == alr_pkg::OFFSET_W'(1)) begin
                o_state.payload_total = {i_byte, st.length_low};
            end
            last_off = {1'b0, o_state.payload_total} + alr_pkg::HEADER_LAST;
            // close on the last byte of header plus payload
            if ((st.bytes_received >= alr_pkg::HEADER_LAST) &&
                (st.bytes_received == last_off)) begin
                o_result.frame_end     = 1'b1;
                o_state.frame_open     = 1'b0;
                o_state.bytes_received = '0;
            end else begin
                o_state.bytes_received = st.bytes_received + alr_pkg::OFFSET_W'(1);
            end
        end
    end

endmodule

// ----- src/acl_l2cap_reassembly.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_l2cap_reassembly
// A result item is registered in stage 1, then in the output register.
// Throughput: one byte per cycle unless the output stalls; the slot state memory
// is read on accept and written back as the item leaves stage 1, with a same-slot bypass.
// Reset: synchronous, active low; clears all slot registers, the state memory
// written marks and the pipeline valids. No clearing pass is needed.
// ----------------------------------------------------------------------------
module acl_l2cap_reassembly (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [alr_pkg::ADDR_W-1:0]    paddr,
    input  logic [alr_pkg::DATA_W-1:0]    pwdata,
    output logic [alr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [alr_pkg::HANDLE_W-1:0]  i_conn_handle,
    input  logic [alr_pkg::CODE_W-1:0]    i_boundary_code,
    input  logic                          i_first_of_packet,
    input  logic [alr_pkg::BYTE_W-1:0]    i_payload_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [alr_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [alr_pkg::BYTE_W-1:0]    o_frame_byte,
    output logic [alr_pkg::OFFSET_W-1:0]  o_frame_offset,
    output logic                          o_frame_end,
    output logic                          o_previous_discarded
);

    alr_pkg::t_match               match;
    alr_pkg::t_slot_state          rd_state;
    alr_pkg::t_slot_state          cur_state;
    alr_pkg::t_slot_state          new_state;
    alr_pkg::t_result              result;
    logic                          in_fire;
    logic                          s1_adv;

    logic                          r_s1_valid;
    logic [alr_pkg::SLOT_W-1:0]    r_s1_slot;
    logic [alr_pkg::CODE_W-1:0]    r_s1_code;
    logic                          r_s1_first;
    logic [alr_pkg::BYTE_W-1:0]    r_s1_byte;
    logic                          r_byp_valid;
    alr_pkg::t_slot_state          r_byp_state;

    logic                          r_out_valid;
    logic [alr_pkg::SLOT_W-1:0]    r_out_slot;
    logic [alr_pkg::BYTE_W-1:0]    r_out_byte;
    logic [alr_pkg::OFFSET_W-1:0]  r_out_offset;
    logic                          r_out_end;
    logic                          r_out_disc;

    alr_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_handle (i_conn_handle),
        .o_match  (match)
    );

    // advance stage 1 when the output register is free or being taken
    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_fire = i_valid && o_ready;

    alr_state_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (match.slot),
        .o_rd_data (rd_state),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_slot),
        .i_wr_data (new_state)
    );

    // take the bypassed state when the previous item wrote the same slot
    assign cur_state = r_byp_valid ? r_byp_state : rd_state;

    alr_frame_update u_upd (
        .i_state  (cur_state),
        .i_code   (r_s1_code),
        .i_first  (r_s1_first),
        .i_byte   (r_s1_byte),
        .o_state  (new_state),
        .o_result (result)
    );

    // stage 1: item with a known handle, waiting on its state read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_byp_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid  <= match.hit;
            r_byp_valid <= s1_adv && (r_s1_slot == match.slot);
        end else if (s1_adv) begin
            r_s1_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_slot   <= match.slot;
            r_s1_code   <= i_boundary_code;
            r_s1_first  <= i_first_of_packet;
            r_s1_byte   <= i_payload_byte;
            r_byp_state <= new_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= result.emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && result.emit) begin
            r_out_slot   <= r_s1_slot;
            r_out_byte   <= r_s1_byte;
            r_out_offset <= result.offset;
            r_out_end    <= result.frame_end;
            r_out_disc   <= result.discarded;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_slot_index         = r_out_slot;
    assign o_frame_byte         = r_out_byte;
    assign o_frame_offset       = r_out_offset;
    assign o_frame_end          = r_out_end;
    assign o_previous_discarded = r_out_disc;

endmodule

// ----- src/alr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alr_checker
// Port-level checks on the reassembly block's result items.
// ----------------------------------------------------------------------------
module alr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [alr_pkg::BYTE_W-1:0]    o_frame_byte,
    input  logic [alr_pkg::OFFSET_W-1:0]  o_frame_offset,
    input  logic                          o_frame_end,
    input  logic                          o_previous_discarded
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_byte)
                                && $stable(o_frame_offset))
        else $error("result item changed while stalled");

    // a frame never ends inside its header
    a_end_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_frame_offset >= alr_pkg::HEADER_LAST)
        else $error("frame end inside header");

    // a discard mark only comes on the first byte of a new frame
    a_disc_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_previous_discarded |-> o_frame_offset == '0)
        else $error("discard mark off frame start");

    // no item right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result item after reset");

endmodule

bind acl_l2cap_reassembly alr_checker u_alr_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_valid              (o_valid),
    .i_ready              (i_ready),
    .o_frame_byte         (o_frame_byte),
    .o_frame_offset       (o_frame_offset),
    .o_frame_end          (o_frame_end),
    .o_previous_discarded (o_previous_discarded)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ACL to L2CAP reassembly block. Slot handles and
// the enable mask are set over the APB port between traffic phases. Tagged
// ACL bytes are fed through a valid/ready driver with random gaps, and every
// frame byte that comes out is checked field by field against an in-bench
// model of the per-slot frame state.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 500000;

    // one ACL byte with its tags
    typedef struct packed {
        logic [alr_pkg::HANDLE_W-1:0] handle;
        logic [alr_pkg::CODE_W-1:0]   code;
        logic                         first;
        logic [alr_pkg::BYTE_W-1:0]   data;
    } t_acl_byte;

    // one reassembled frame byte
    typedef struct packed {
        logic [alr_pkg::SLOT_W-1:0]   slot;
        logic [alr_pkg::BYTE_W-1:0]   data;
        logic [alr_pkg::OFFSET_W-1:0] offset;
        logic                         frame_end;
        logic                         discarded;
    } t_frame_byte;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [alr_pkg::ADDR_W-1:0]    paddr = '0;
    logic [alr_pkg::DATA_W-1:0]    pwdata = '0;
    logic [alr_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [alr_pkg::HANDLE_W-1:0]  i_conn_handle = '0;
    logic [alr_pkg::CODE_W-1:0]    i_boundary_code = '0;
    logic                          i_first_of_packet = 1'b0;
    logic [alr_pkg::BYTE_W-1:0]    i_payload_byte = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [alr_pkg::SLOT_W-1:0]    o_slot_index;
    logic [alr_pkg::BYTE_W-1:0]    o_frame_byte;
    logic [alr_pkg::OFFSET_W-1:0]  o_frame_offset;
    logic                          o_frame_end;
    logic                          o_previous_discarded;

    // slot setup as last written
    logic [alr_pkg::HANDLE_W-1:0]         cfg_handle [alr_pkg::CONNECTION_SLOTS];
    logic [alr_pkg::CONNECTION_SLOTS-1:0] cfg_enable;

    // per-slot frame state of the model
    logic                         frame_open    [alr_pkg::CONNECTION_SLOTS];
    logic [alr_pkg::TOTAL_W-1:0]  payload_total [alr_pkg::CONNECTION_SLOTS];
    logic [alr_pkg::OFFSET_W-1:0] rx_count      [alr_pkg::CONNECTION_SLOTS];
    logic [alr_pkg::BYTE_W-1:0]   len_low       [alr_pkg::CONNECTION_SLOTS];

    t_acl_byte   acl_pending [$];
    t_frame_byte frame_expected [$];
    t_acl_byte   cur_byte;
    t_frame_byte want;

    // generator view of each slot's frame in progress
    int gen_pos [alr_pkg::CONNECTION_SLOTS];
    int gen_len [alr_pkg::CONNECTION_SLOTS];

    logic feeding = 1'b0;
    logic idle_en = 1'b1;
    int   send_gap = 0;
    int   take_gap = 0;
    int   cycles = 0;
    int   errors = 0;
    int   bytes_sent = 0;
    int   bytes_checked = 0;
    int   frames_done = 0;
    int   frames_dropped = 0;
    int   setups = 0;

    acl_l2cap_reassembly i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_conn_handle       (i_conn_handle),
        .i_boundary_code     (i_boundary_code),
        .i_first_of_packet   (i_first_of_packet),
        .i_payload_byte      (i_payload_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_slot_index        (o_slot_index),
        .o_frame_byte        (o_frame_byte),
        .o_frame_offset      (o_frame_offset),
        .o_frame_end         (o_frame_end),
        .o_previous_discarded(o_previous_discarded)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cfg_enable = '0;
        for (int j = 0; j < alr_pkg::CONNECTION_SLOTS; j++) begin
            cfg_handle[j]    = '0;
            frame_open[j]    = 1'b0;
            payload_total[j] = '0;
            rx_count[j]      = '0;
            len_low[j]       = '0;
        end
    end

    // Advance the slot model by one accepted byte; queue the frame byte it yields.
    function automatic void reassemble_byte(input t_acl_byte it);
        int                           s;
        logic [alr_pkg::OFFSET_W-1:0] off;
        logic                         disc;
        t_frame_byte                  fb;
        s    = -1;
        disc = 1'b0;
        // lowest enabled slot with a matching handle wins
        for (int k = alr_pkg::CONNECTION_SLOTS - 1; k >= 0; k--) begin
            if (cfg_enable[k] && cfg_handle[k] == it.handle)
                s = k;
        end
        if (s < 0)
            return;
        if (it.first && it.code == alr_pkg::START_CODE) begin
            disc             = frame_open[s];
            frame_open[s]    = 1'b1;
            rx_count[s]      = '0;
            payload_total[s] = '0;
            len_low[s]       = '0;
        end
        if (!frame_open[s])
            return;
        off = rx_count[s];
        if (off == 0)
            len_low[s] = it.data;
        else if (off == 1)
            payload_total[s] = {it.data, len_low[s]};
        fb.slot      = alr_pkg::SLOT_W'(s);
        fb.data      = it.data;
        fb.offset    = off;
        fb.discarded = disc;
        fb.frame_end = 1'b0;
        if (off >= alr_pkg::HEADER_LAST &&
            off == alr_pkg::OFFSET_W'(payload_total[s]) + alr_pkg::HEADER_LAST) begin
            fb.frame_end  = 1'b1;
            frame_open[s] = 1'b0;
            rx_count[s]   = '0;
        end else begin
            rx_count[s] = off + 1'b1;
        end
        frame_expected.push_back(fb);
    endfunction

    // Drive one ACL byte per handshake, with a random gap before each.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            feeding  = 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                reassemble_byte(cur_byte);
                feeding  = 1'b0;
                bytes_sent++;
                send_gap = idle_en ? $urandom_range(0, 6) : 0;
            end
            if (!feeding) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (acl_pending.size() != 0) begin
                    cur_byte = acl_pending.pop_front();
                    feeding  = 1'b1;
                    i_conn_handle     <= cur_byte.handle;
                    i_boundary_code   <= cur_byte.code;
                    i_first_of_packet <= cur_byte.first;
                    i_payload_byte    <= cur_byte.data;
                end
            end
            i_valid <= feeding;
        end
    end

    // Take frame bytes with random stalls and check each against the oldest expected.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready  <= 1'b0;
            take_gap = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (frame_expected.size() == 0) begin
                    $error("unexpected frame byte: slot %0d byte %h offset %0d",
                           o_slot_index, o_frame_byte, o_frame_offset);
                    errors++;
                end else begin
                    want = frame_expected.pop_front();
                    if (o_slot_index !== want.slot) begin
                        $error("slot_index: expected %0d, got %0d", want.slot, o_slot_index);
                        errors++;
                    end
                    if (o_frame_byte !== want.data) begin
                        $error("frame_byte: expected %h, got %h", want.data, o_frame_byte);
                        errors++;
                    end
                    if (o_frame_offset !== want.offset) begin
                        $error("frame_offset: expected %0d, got %0d",
                               want.offset, o_frame_offset);
                        errors++;
                    end
                    if (o_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, got %0d", want.frame_end, o_frame_end);
                        errors++;
                    end
                    if (o_previous_discarded !== want.discarded) begin
                        $error("previous_discarded: expected %0d, got %0d",
                               want.discarded, o_previous_discarded);
                        errors++;
                    end
                    if (want.frame_end)
                        frames_done++;
                    if (want.discarded)
                        frames_dropped++;
                end
                bytes_checked++;
                take_gap = idle_en ? $urandom_range(0, 6) : 0;
            end
            if (take_gap > 0) begin
                take_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(input alr_pkg::t_reg_idx idx,
                             input logic [alr_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == alr_pkg::REG_ENABLE)
            cfg_enable = value[alr_pkg::CONNECTION_SLOTS-1:0];
        else
            cfg_handle[int'(idx)] = value[alr_pkg::HANDLE_W-1:0];
    endtask

    // Write all slot registers; junk in the unused upper bits.
    task automatic set_slots(input logic [alr_pkg::HANDLE_W-1:0] h0,
                             input logic [alr_pkg::HANDLE_W-1:0] h1,
                             input logic [alr_pkg::HANDLE_W-1:0] h2,
                             input logic [alr_pkg::HANDLE_W-1:0] h3,
                             input logic [alr_pkg::CONNECTION_SLOTS-1:0] mask);
        write_reg(alr_pkg::REG_HANDLE_0, {20'($urandom), h0});
        write_reg(alr_pkg::REG_HANDLE_1, {20'($urandom), h1});
        write_reg(alr_pkg::REG_HANDLE_2, {20'($urandom), h2});
        write_reg(alr_pkg::REG_HANDLE_3, {20'($urandom), h3});
        write_reg(alr_pkg::REG_ENABLE, {28'($urandom), mask});
        setups++;
    endtask

    // Hold until every byte is sent and every frame byte is back, then let the pipe empty.
    task automatic drain();
        while (acl_pending.size() != 0 || feeding || frame_expected.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic void push_byte(input logic [alr_pkg::HANDLE_W-1:0] h,
                                      input logic [alr_pkg::CODE_W-1:0] c,
                                      input logic f,
                                      input logic [alr_pkg::BYTE_W-1:0] d);
        t_acl_byte it;
        it.handle = h;
        it.code   = c;
        it.first  = f;
        it.data   = d;
        acl_pending.push_back(it);
    endfunction

    // Interleaved ACL packets carrying well-formed frames, plus noise,
    // stray continuations and restarts of unfinished frames.
    task automatic gen_traffic(input int n_items);
        int        made;
        int        tries;
        int        k;
        int        j;
        int        n;
        int        roll;
        int        plen;
        logic      start;
        t_acl_byte it;
        made  = 0;
        tries = 0;
        for (j = 0; j < alr_pkg::CONNECTION_SLOTS; j++) begin
            gen_pos[j] = 0;
            gen_len[j] = 0;
        end
        while (made < n_items && tries < 4 * n_items) begin
            k = $urandom_range(0, alr_pkg::CONNECTION_SLOTS - 1);
            while (cfg_enable != 0 && !cfg_enable[k] && $urandom_range(0, 3) != 0)
                k = $urandom_range(0, alr_pkg::CONNECTION_SLOTS - 1);
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                // noise: any handle, any flags
                push_byte(alr_pkg::HANDLE_W'($urandom_range(0, 4095)),
                          alr_pkg::CODE_W'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)),
                          alr_pkg::BYTE_W'($urandom_range(0, 255)));
                tries++;
                made++;
            end else begin
                // restart mid-frame, stray continuation, or the next packet of a frame
                start = (roll < 14) || (roll >= 18 && gen_pos[k] >= gen_len[k]);
                if (start) begin
                    plen = ($urandom_range(0, 99) < 4) ? $urandom_range(100, 300)
                                                       : $urandom_range(0, 20);
                    gen_pos[k] = 0;
                    gen_len[k] = plen + 4;
                end
                n = $urandom_range(1, 8);
                if (gen_pos[k] < gen_len[k] && n > gen_len[k] - gen_pos[k])
                    n = gen_len[k] - gen_pos[k];
                for (j = 0; j < n; j++) begin
                    it.handle = cfg_handle[k];
                    it.first  = (j == 0);
                    it.code   = alr_pkg::CODE_W'($urandom_range(0, 3));
                    if (j == 0) begin
                        if (start)
                            it.code = alr_pkg::START_CODE;
                        else if (it.code == alr_pkg::START_CODE)
                            it.code = 2'd3;
                    end
                    if (gen_pos[k] == 0)
                        it.data = alr_pkg::BYTE_W'(gen_len[k] - 4);
                    else if (gen_pos[k] == 1)
                        it.data = alr_pkg::BYTE_W'((gen_len[k] - 4) >> 8);
                    else
                        it.data = alr_pkg::BYTE_W'($urandom_range(0, 255));
                    if (gen_pos[k] < gen_len[k])
                        gen_pos[k]++;
                    acl_pending.push_back(it);
                    tries++;
                    made++;
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: slots 1 and 3 share a handle, so slot 1 must take it
        set_slots(12'h000, 12'hFFF, 12'h5A5, 12'hFFF, 4'hF);
        push_byte(12'h007, alr_pkg::START_CODE, 1'b1, 8'h11);   // unknown handle
        push_byte(12'h000, 2'd0, 1'b0, 8'h22);                  // no open frame
        push_byte(12'h000, alr_pkg::START_CODE, 1'b1, 8'h00);   // header-only frame
        push_byte(12'h000, 2'd0, 1'b0, 8'h00);
        push_byte(12'h000, 2'd1, 1'b0, 8'hAA);
        push_byte(12'h000, 2'd3, 1'b0, 8'h55);
        push_byte(12'h000, 2'd0, 1'b0, 8'h77);                  // past the end
        push_byte(12'hFFF, alr_pkg::START_CODE, 1'b1, 8'h02);
        push_byte(12'hFFF, 2'd0, 1'b0, 8'h00);
        push_byte(12'h5A5, alr_pkg::START_CODE, 1'b1, 8'hFF);   // longest length, interleaved
        push_byte(12'h5A5, 2'd0, 1'b0, 8'hFF);
        push_byte(12'hFFF, 2'd0, 1'b0, 8'h01);
        push_byte(12'hFFF, 2'd0, 1'b0, 8'h00);
        push_byte(12'hFFF, 2'd1, 1'b1, 8'hFF);                  // non-start first byte continues
        push_byte(12'hFFF, 2'd0, 1'b0, 8'h80);
        push_byte(12'h5A5, 2'd0, 1'b0, 8'h12);
        push_byte(12'h5A5, 2'd3, 1'b1, 8'h34);
        push_byte(12'h5A5, 2'd0, 1'b0, 8'hC3);
        push_byte(12'h5A5, alr_pkg::START_CODE, 1'b1, 8'h01);   // restart drops the open frame
        push_byte(12'h5A5, 2'd0, 1'b0, 8'h00);
        push_byte(12'h5A5, 2'd0, 1'b0, 8'h40);
        push_byte(12'h5A5, 2'd0, 1'b0, 8'h00);
        push_byte(12'h5A5, 2'd0, 1'b0, 8'hE7);
        push_byte(12'h000, 2'd3, 1'b1, 8'h99);                  // first byte, closed slot
        push_byte(12'h000, 2'd0, 1'b1, 8'h98);
        drain();

        // random traffic over a range of slot setups
        set_slots(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 4'hF);
        gen_traffic(400);
        drain();

        idle_en = 1'b0;
        set_slots(12'h001, 12'h002, 12'h800, 12'h7FF, 4'hF);
        gen_traffic(350);
        drain();
        idle_en = 1'b1;

        set_slots(12'h000, 12'hFFF, 12'($urandom_range(0, 4095)), 12'h0F0, 4'h5);
        gen_traffic(350);
        drain();

        set_slots(12'h3C3, 12'hC3C, 12'h3C3, 12'hC3C, 4'hE);
        gen_traffic(350);
        drain();

        set_slots(12'h000, 12'hFFF, 12'h555, 12'hAAA, 4'h0);
        gen_traffic(40);
        drain();

        set_slots(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  4'($urandom_range(1, 15)));
        gen_traffic(350);
        drain();

        $display("%0d ACL bytes sent over %0d slot setups; %0d frame bytes checked,",
                 bytes_sent, setups, bytes_checked);
        $display("%0d frames completed, %0d unfinished frames dropped on restart",
                 frames_done, frames_dropped);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
